// ----- src/vslg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vslg_pkg: shared types and constants of the vehicle speed loop
// Payload structs, configuration register indexes, reset values, helpers.
// ----------------------------------------------------------------------------
package vslg_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INJECT_KP     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INJECT_KI     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BRAKE_KP      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_VELOCITY_MAX  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_VEHICLE_MASS  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_PEAK_SPEED    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_GEAR_RATIOS   = 3'd7;

  // register reset values
  localparam logic [16:0] RST_SAMPLE_PERIOD = 17'd655;
  localparam logic [24:0] RST_INJECT_KP     = 25'd65536;
  localparam logic [24:0] RST_INJECT_KI     = 25'd6554;
  localparam logic [24:0] RST_BRAKE_KP      = 25'd65536;
  localparam logic [30:0] RST_VELOCITY_MAX  = 31'd655360;
  localparam logic [30:0] RST_VEHICLE_MASS  = 31'd6553600;
  localparam logic [30:0] RST_PEAK_SPEED    = 31'd6553600;
  localparam logic [63:0] RST_GEAR_RATIOS   = 64'd72059243338924800;

  // input transaction payload
  typedef struct packed {
    logic signed [31:0] target_speed;
  } vslg_in_t;

  // result transaction payload
  typedef struct packed {
    logic signed [31:0] speed;
    logic [1:0]         gear_now;
    logic signed [31:0] drive_force;
  } vslg_out_t;

  // clamp a wide value to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    logic signed [31:0] r;
    if (x > 72'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -72'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Q8.8 ratio of one gear out of the packed register
  function automatic logic [15:0] ratio_of(input logic [63:0] gr, input logic [1:0] g);
    return gr[16*g +: 16];
  endfunction

endpackage

// ----- src/vslg_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vslg_chan_if: valid/ready channel
// Carries one payload per transaction, accepted when valid and ready are high.
// ----------------------------------------------------------------------------
interface vslg_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/vehicle_speed_loop_with_gearbox.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_speed_loop_with_gearbox: car speed loop with PI drive and gearbox
// One transaction per control tick: picks a drive force, a brake force or none, shifts
// gear and integrates the vehicle speed, all in Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in_if     in   valid / ready        target_speed
//  out_if    out  valid / ready        speed, gear_now, drive_force
//  cfg       in   cfg_we (no stall)    cfg_addr, cfg_wdata
//
//  One shared multiplier and one radix-2 divider (three quotients on the drive
//  path) do the arithmetic of every tick in turn. Reset is synchronous; no
//  clearing pass.
//  A result waits in the output register; a new tick is taken meanwhile and
//  holds before its commit until the previous result has left.
// ----------------------------------------------------------------------------
module vehicle_speed_loop_with_gearbox #(
  parameter int GEAR_COUNT       = 4,
  parameter int TORQUE_DROOP_Q16 = 16384,
  parameter int PEAK_TORQUE_Q16  = 13107200
) (
  input  logic                           clk,
  input  logic                           rst_n,
  vslg_chan_if.sink                      in_if,
  vslg_chan_if.source                    out_if,
  input  logic                           cfg_we,
  input  logic [vslg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [vslg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vslg_pkg::*;

  // sequencer states
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_ERR     = 5'd1;
  localparam logic [4:0] ST_DR_INT  = 5'd2;
  localparam logic [4:0] ST_DR_KP   = 5'd3;
  localparam logic [4:0] ST_DR_KI   = 5'd4;
  localparam logic [4:0] ST_DR_U    = 5'd5;
  localparam logic [4:0] ST_DR_CMD  = 5'd6;
  localparam logic [4:0] ST_DR_UP   = 5'd7;
  localparam logic [4:0] ST_DR_OMG  = 5'd8;
  localparam logic [4:0] ST_DR_WN   = 5'd9;
  localparam logic [4:0] ST_DR_X    = 5'd10;
  localparam logic [4:0] ST_DR_SQ   = 5'd11;
  localparam logic [4:0] ST_DR_SQH  = 5'd12;
  localparam logic [4:0] ST_DR_F    = 5'd13;
  localparam logic [4:0] ST_DR_CRV  = 5'd14;
  localparam logic [4:0] ST_DR_TRQ  = 5'd15;
  localparam logic [4:0] ST_DR_FRC  = 5'd16;
  localparam logic [4:0] ST_BK_P    = 5'd17;
  localparam logic [4:0] ST_BK_DIV  = 5'd18;
  localparam logic [4:0] ST_BK_CMD  = 5'd19;
  localparam logic [4:0] ST_BK_DN   = 5'd20;
  localparam logic [4:0] ST_BK_FRC  = 5'd21;
  localparam logic [4:0] ST_SP_MUL  = 5'd22;
  localparam logic [4:0] ST_SP_DIV  = 5'd23;
  localparam logic [4:0] ST_SP_ADD  = 5'd24;
  localparam logic [4:0] ST_DONE    = 5'd25;
  localparam logic [4:0] ST_DV_SET  = 5'd26;
  localparam logic [4:0] ST_DV_RUN  = 5'd27;
  localparam logic [4:0] ST_DV_END  = 5'd28;

  // configuration registers
  logic [16:0] sp_r;
  logic [24:0] kp_r, ki_r, bkp_r;
  logic [30:0] vmax_r, mass_r, wmax_r;
  logic [63:0] gr_r;

  // architectural state
  logic signed [31:0] v_r, integ_r, lerr_r;
  logic [1:0]         gear_r;

  // sequencer and working registers
  logic [4:0]         state_r, ret_r;
  logic signed [31:0] tgt_r, err_r, i_r, cmd_r, force_r, spd_new_r;
  logic signed [67:0] acc_r, prod_r;
  logic [46:0]        sq_r;
  logic [1:0]         gear_w_r;

  // divider registers
  logic signed [63:0] div_n_r;
  logic [30:0]        div_d_r;
  logic signed [33:0] div_q_r;
  logic [30:0]        rem_r;
  logic [31:0]        quo_r;
  logic               neg_r, ovf_r;
  logic [4:0]         cnt_r;

  // output register
  logic      out_valid_r;
  vslg_out_t out_data_r;

  // combinational helpers
  logic signed [33:0] mul_a, mul_b;
  logic signed [71:0] prod72, u_c, dsq_c, tenvr_c, up_thr_c, dn_thr_c, m_c;
  logic signed [31:0] err_c, i_c, f_c, shr16_c, shr8_c;
  logic signed [33:0] x_c;
  logic [30:0]        vmax_nz, mass_nz, wmax_nz;
  logic [46:0]        sq_c;
  logic [63:0]        dv_mag;
  logic               dv_ovf;
  logic [31:0]        rem_sh;
  logic               rem_ge;
  logic [33:0]        dv_qmag;
  logic               out_free;

  assign vmax_nz = (vmax_r == '0) ? 31'd1 : vmax_r;
  assign mass_nz = (mass_r == '0) ? 31'd1 : mass_r;
  assign wmax_nz = (wmax_r == '0) ? 31'd1 : wmax_r;

  // handshake
  assign in_if.ready  = (state_r == ST_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;
  assign out_free     = !out_valid_r || out_if.ready;

  // arithmetic on the previous product
  always_comb begin
    prod72   = 72'(prod_r);
    err_c    = sat32(72'(tgt_r) - 72'(v_r));
    i_c      = sat32(72'(integ_r) + (prod72 >>> 17));
    u_c      = (72'(acc_r) + prod72) >>> 16;
    if (u_c > $signed({41'b0, vmax_r})) begin
      u_c = $signed({41'b0, vmax_r});
    end
    tenvr_c  = (prod72 <<< 3) + (prod72 <<< 1);
    up_thr_c = $signed({41'b0, wmax_nz} << 10) + $signed({41'b0, wmax_nz} << 9)
             + $signed({41'b0, wmax_nz} << 8);
    dn_thr_c = $signed({41'b0, wmax_nz} << 10) + $signed({41'b0, wmax_nz} << 9);
    x_c      = 34'(sat32(72'(div_q_r))) - 34'sd65536;
    sq_c     = prod_r[62:16];
    dsq_c    = ((prod72 <<< 23) + 72'(acc_r)) >>> 16;
    f_c      = sat32(72'sd65536 - dsq_c);
    shr16_c  = sat32(prod72 >>> 16);
    shr8_c   = sat32(prod72 >>> 8);
    m_c      = prod72 >>> 16;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_DR_INT: begin
        mul_a = $signed({17'b0, sp_r});
        mul_b = 34'(err_r) + 34'(lerr_r);
      end
      ST_DR_KP: begin
        mul_a = $signed({9'b0, kp_r});
        mul_b = 34'(err_r);
      end
      ST_DR_KI: begin
        mul_a = $signed({9'b0, ki_r});
        mul_b = 34'(i_r);
      end
      ST_DR_CMD, ST_BK_CMD: begin
        mul_a = 34'(v_r);
        mul_b = $signed({18'b0, ratio_of(gr_r, gear_r)});
      end
      ST_DR_OMG: begin
        mul_a = 34'(v_r);
        mul_b = $signed({18'b0, ratio_of(gr_r, gear_w_r)});
      end
      ST_DR_X: begin
        mul_a = x_c;
        mul_b = x_c;
      end
      ST_DR_SQ: begin
        mul_a = 34'(TORQUE_DROOP_Q16);
        mul_b = $signed({11'b0, sq_c[22:0]});
      end
      ST_DR_SQH: begin
        mul_a = 34'(TORQUE_DROOP_Q16);
        mul_b = $signed({10'b0, sq_r[46:23]});
      end
      ST_DR_F: begin
        mul_a = 34'(PEAK_TORQUE_Q16);
        mul_b = 34'(f_c);
      end
      ST_DR_CRV: begin
        mul_a = 34'(shr16_c);
        mul_b = 34'(cmd_r);
      end
      ST_DR_TRQ: begin
        mul_a = 34'(shr16_c);
        mul_b = $signed({18'b0, ratio_of(gr_r, gear_w_r)});
      end
      ST_BK_P: begin
        mul_a = $signed({9'b0, bkp_r});
        mul_b = -34'(err_r);
      end
      ST_BK_DN: begin
        mul_a = $signed({3'b0, mass_nz});
        mul_b = 34'(cmd_r);
      end
      ST_SP_MUL: begin
        mul_a = 34'(force_r);
        mul_b = $signed({17'b0, sp_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider step logic
  always_comb begin
    dv_mag  = div_n_r[63] ? 64'(-div_n_r) : 64'(div_n_r);
    dv_ovf  = dv_mag >= {1'b0, div_d_r, 32'b0};
    rem_sh  = {rem_r, quo_r[31]};
    rem_ge  = rem_sh >= {1'b0, div_d_r};
    dv_qmag = ovf_r ? 34'h1_0000_0000 : {2'b0, quo_r};
  end

  // multiplier output register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= RST_SAMPLE_PERIOD;
      kp_r   <= RST_INJECT_KP;
      ki_r   <= RST_INJECT_KI;
      bkp_r  <= RST_BRAKE_KP;
      vmax_r <= RST_VELOCITY_MAX;
      mass_r <= RST_VEHICLE_MASS;
      wmax_r <= RST_PEAK_SPEED;
      gr_r   <= RST_GEAR_RATIOS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SAMPLE_PERIOD: sp_r   <= cfg_wdata[16:0];
        REG_INJECT_KP:     kp_r   <= cfg_wdata[24:0];
        REG_INJECT_KI:     ki_r   <= cfg_wdata[24:0];
        REG_BRAKE_KP:      bkp_r  <= cfg_wdata[24:0];
        REG_VELOCITY_MAX:  vmax_r <= cfg_wdata[30:0];
        REG_VEHICLE_MASS:  mass_r <= cfg_wdata[30:0];
        REG_PEAK_SPEED:    wmax_r <= cfg_wdata[30:0];
        REG_GEAR_RATIOS:   gr_r   <= cfg_wdata;
        default:           gr_r   <= gr_r;
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      v_r     <= '0;
      integ_r <= '0;
      lerr_r  <= '0;
      gear_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            tgt_r   <= in_if.data.target_speed;
            state_r <= ST_ERR;
          end
        end
        // error and path selection
        ST_ERR: begin
          err_r    <= err_c;
          gear_w_r <= gear_r;
          force_r  <= '0;
          if (!tgt_r[31] && err_c > 32'sd0) begin
            state_r <= ST_DR_INT;
          end else if (!tgt_r[31] && err_c < 32'sd0) begin
            state_r <= ST_BK_P;
          end else begin
            state_r <= ST_SP_MUL;
          end
        end
        // drive: trapezoidal integrator and PI command
        ST_DR_INT: state_r <= ST_DR_KP;
        ST_DR_KP: begin
          i_r     <= i_c;
          state_r <= ST_DR_KI;
        end
        ST_DR_KI: begin
          acc_r   <= prod_r;
          state_r <= ST_DR_U;
        end
        ST_DR_U: begin
          div_n_r <= 64'(u_c <<< 16);
          div_d_r <= vmax_nz;
          ret_r   <= ST_DR_CMD;
          state_r <= ST_DV_SET;
        end
        ST_DR_CMD: begin
          cmd_r   <= sat32(72'(div_q_r));
          state_r <= ST_DR_UP;
        end
        // upshift check
        ST_DR_UP: begin
          if (32'(gear_r) < GEAR_COUNT - 1 && tenvr_c > up_thr_c) begin
            gear_w_r <= gear_r + 2'd1;
          end
          state_r <= ST_DR_OMG;
        end
        ST_DR_OMG: state_r <= ST_DR_WN;
        ST_DR_WN: begin
          div_n_r <= 64'((prod72 >>> 8) <<< 16);
          div_d_r <= wmax_nz;
          ret_r   <= ST_DR_X;
          state_r <= ST_DV_SET;
        end
        // torque curve
        ST_DR_X: state_r <= ST_DR_SQ;
        ST_DR_SQ: begin
          sq_r    <= sq_c;
          state_r <= ST_DR_SQH;
        end
        ST_DR_SQH: begin
          acc_r   <= prod_r;
          state_r <= ST_DR_F;
        end
        ST_DR_F:   state_r <= ST_DR_CRV;
        ST_DR_CRV: state_r <= ST_DR_TRQ;
        ST_DR_TRQ: state_r <= ST_DR_FRC;
        ST_DR_FRC: begin
          force_r <= shr8_c;
          integ_r <= i_r;
          lerr_r  <= err_r;
          state_r <= ST_SP_MUL;
        end
        // brake path
        ST_BK_P: state_r <= ST_BK_DIV;
        ST_BK_DIV: begin
          div_n_r <= 64'((prod72 >>> 16) <<< 16);
          div_d_r <= vmax_nz;
          ret_r   <= ST_BK_CMD;
          state_r <= ST_DV_SET;
        end
        ST_BK_CMD: begin
          cmd_r   <= sat32(72'(div_q_r));
          state_r <= ST_BK_DN;
        end
        ST_BK_DN: begin
          if (gear_r != 2'd0 && tenvr_c < dn_thr_c) begin
            gear_w_r <= gear_r - 2'd1;
          end
          state_r <= ST_BK_FRC;
        end
        ST_BK_FRC: begin
          force_r <= sat32(-((m_c <<< 2) + m_c));
          state_r <= ST_SP_MUL;
        end
        // speed integration
        ST_SP_MUL: state_r <= ST_SP_DIV;
        ST_SP_DIV: begin
          div_n_r <= 64'(prod72);
          div_d_r <= mass_nz;
          ret_r   <= ST_SP_ADD;
          state_r <= ST_DV_SET;
        end
        ST_SP_ADD: begin
          spd_new_r <= sat32(72'(v_r) + 72'(div_q_r));
          state_r   <= ST_DONE;
        end
        // commit once the output register is free
        ST_DONE: begin
          if (out_free) begin
            v_r                    <= spd_new_r;
            gear_r                 <= gear_w_r;
            out_data_r.speed       <= spd_new_r;
            out_data_r.gear_now    <= gear_w_r;
            out_data_r.drive_force <= force_r;
            state_r                <= ST_IDLE;
          end
        end
        // shared divider, truncating, quotient clamped to 2^32
        ST_DV_SET: begin
          neg_r   <= div_n_r[63];
          ovf_r   <= dv_ovf;
          rem_r   <= dv_mag[62:32];
          quo_r   <= dv_mag[31:0];
          cnt_r   <= '0;
          state_r <= dv_ovf ? ST_DV_END : ST_DV_RUN;
        end
        ST_DV_RUN: begin
          rem_r   <= rem_ge ? 31'(rem_sh - {1'b0, div_d_r}) : rem_sh[30:0];
          quo_r   <= {quo_r[30:0], rem_ge};
          cnt_r   <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= ST_DV_END;
          end
        end
        ST_DV_END: begin
          div_q_r <= neg_r ? -$signed(dv_qmag) : $signed(dv_qmag);
          state_r <= ret_r;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // gear stays within the gearbox
  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(gear_r) <= GEAR_COUNT - 1)
    else $error("gear beyond last gear");

  // gear moves by at most one per tick
  a_gear_step: assert property (@(posedge clk) disable iff (!rst_n)
    gear_r != $past(gear_r) |->
      ({1'b0, gear_r} == {1'b0, $past(gear_r)} + 3'd1) ||
      ({1'b0, gear_r} + 3'd1 == {1'b0, $past(gear_r)}))
    else $error("gear jumped");

  // negative target gives no force
  a_neg_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && tgt_r[31]) |-> force_r == 32'sd0)
    else $error("force on negative target");

  // braking never pushes forward
  a_brake_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !tgt_r[31] && err_r[31]) |->
      (force_r[31] || force_r == 32'sd0))
    else $error("brake force positive");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the vehicle speed loop with gearbox
// Drives target speeds in random bursts, predicts speed, gear and force per
// tick in fixed point, and compares every result transaction field by field
// across several gain, mass, period and gear ratio settings.
// ----------------------------------------------------------------------------
module tb_top;
  import vslg_pkg::*;

  localparam int  NUM_GEARS  = 4;
  localparam longint DROOP   = 16384;
  localparam longint PEAK_TQ = 13107200;
  localparam longint S32_HI  = 64'sd2147483647;
  localparam longint S32_LO  = -64'sd2147483648;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  vslg_chan_if #(.payload_t(vslg_in_t))  in_ch ();
  vslg_chan_if #(.payload_t(vslg_out_t)) out_ch ();

  vehicle_speed_loop_with_gearbox i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // pending targets and expected results
  logic signed [31:0] target_q[$];
  vslg_out_t          result_q[$];
  int                 fail_cnt = 0;

  // predicted configuration
  longint      period_m, kp_m, ki_m, bkp_m, vmax_m, mass_m, wpk_m;
  logic [63:0] ratios_m;

  // predicted vehicle state
  longint speed_m, integ_m, lerr_m;
  int     gear_m;

  // receiver control
  int stall_mode = 0;
  bit hold_req = 1'b0;

  function automatic longint clip32(longint x);
    if (x > S32_HI) return S32_HI;
    if (x < S32_LO) return S32_LO;
    return x;
  endfunction

  function automatic longint nz(longint x);
    return (x == 0) ? 64'sd1 : x;
  endfunction

  function automatic longint gear_ratio(int g);
    logic [15:0] r;
    r = ratios_m[16*g +: 16];
    return longint'({48'd0, r});
  endfunction

  // one control tick of the speed loop
  function automatic vslg_out_t step_speed_loop(longint tgt);
    vslg_out_t res;
    longint v, err, vmax, wmax, frc, i, u, cmd, omega, x, sq, f, curve, torque, r, p;
    v     = speed_m;
    err   = clip32(tgt - v);
    vmax  = nz(vmax_m);
    wmax  = nz(wpk_m);
    frc   = 0;
    if (tgt >= 0 && err > 0) begin
      i = clip32(integ_m + ((period_m * (err + lerr_m)) >>> 17));
      u = (kp_m * err + ki_m * i) >>> 16;
      if (u > vmax_m) u = vmax_m;
      cmd = clip32(u * 65536 / vmax);
      integ_m = i;
      lerr_m  = err;
      if (gear_m < NUM_GEARS - 1 && 10 * v * gear_ratio(gear_m) > 7 * wmax * 256)
        gear_m++;
      r      = gear_ratio(gear_m);
      omega  = (v * r) >>> 8;
      x      = clip32(omega * 65536 / wmax) - 65536;
      sq     = (x * x) >>> 16;
      f      = clip32(65536 - ((DROOP * sq) >>> 16));
      curve  = clip32((PEAK_TQ * f) >>> 16);
      torque = clip32((curve * cmd) >>> 16);
      frc    = clip32((torque * r) >>> 8);
    end else if (tgt >= 0 && err < 0) begin
      p   = (bkp_m * (-err)) >>> 16;
      cmd = clip32(p * 65536 / vmax);
      if (gear_m > 0 && 10 * v * gear_ratio(gear_m) < 6 * wmax * 256)
        gear_m--;
      frc = clip32(-(5 * ((nz(mass_m) * cmd) >>> 16)));
    end
    speed_m = clip32(v + frc * period_m / nz(mass_m));
    res.speed       = speed_m[31:0];
    res.gear_now    = gear_m[1:0];
    res.drive_force = frc[31:0];
    return res;
  endfunction

  // driver: bursts of transactions with random gaps
  int burst_left = 8;
  int gap_left   = 0;
  always @(posedge clk) begin : drv
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        result_q.push_back(step_speed_loop(longint'(in_ch.data.target_speed)));
        void'(target_q.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
        end
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (target_q.size() > 0) begin
        in_ch.valid             <= 1'b1;
        in_ch.data.target_speed <= target_q[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: ready pattern, long hold-off and result check
  int hold_left = 0;
  int pat_cnt   = 0;
  always @(posedge clk) begin : mon
    vslg_out_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transaction: speed %0d", out_ch.data.speed);
          fail_cnt++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_ch.data.speed !== exp_r.speed) begin
            $error("speed: expected %0d, actual %0d", exp_r.speed, out_ch.data.speed);
            fail_cnt++;
          end
          if (out_ch.data.gear_now !== exp_r.gear_now) begin
            $error("gear_now: expected %0d, actual %0d", exp_r.gear_now,
                   out_ch.data.gear_now);
            fail_cnt++;
          end
          if (out_ch.data.drive_force !== exp_r.drive_force) begin
            $error("drive_force: expected %0d, actual %0d", exp_r.drive_force,
                   out_ch.data.drive_force);
            fail_cnt++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 3000;
      end
      pat_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= ((pat_cnt % 11) < 5);
          default: out_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // run time limit
  int cyc = 0;
  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // register write, mirrored into the prediction
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SAMPLE_PERIOD: period_m = longint'({47'd0, val[16:0]});
      REG_INJECT_KP:     kp_m     = longint'({39'd0, val[24:0]});
      REG_INJECT_KI:     ki_m     = longint'({39'd0, val[24:0]});
      REG_BRAKE_KP:      bkp_m    = longint'({39'd0, val[24:0]});
      REG_VELOCITY_MAX:  vmax_m   = longint'({33'd0, val[30:0]});
      REG_VEHICLE_MASS:  mass_m   = longint'({33'd0, val[30:0]});
      REG_PEAK_SPEED:    wpk_m    = longint'({33'd0, val[30:0]});
      REG_GEAR_RATIOS:   ratios_m = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(logic [63:0] per, logic [63:0] kp, logic [63:0] ki,
                               logic [63:0] bkp, logic [63:0] vmax, logic [63:0] mass,
                               logic [63:0] wpk, logic [63:0] gr);
    cfg_write(REG_SAMPLE_PERIOD, per);
    cfg_write(REG_INJECT_KP, kp);
    cfg_write(REG_INJECT_KI, ki);
    cfg_write(REG_BRAKE_KP, bkp);
    cfg_write(REG_VELOCITY_MAX, vmax);
    cfg_write(REG_VEHICLE_MASS, mass);
    cfg_write(REG_PEAK_SPEED, wpk);
    cfg_write(REG_GEAR_RATIOS, gr);
  endtask

  // wait until every result is back, then let the block settle
  task automatic wait_idle();
    while (target_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random targets: mostly plausible speed profiles, some noise
  task automatic queue_random(int n);
    int sel;
    logic signed [31:0] t;
    logic signed [31:0] cruise;
    cruise = $urandom_range(0, 40) * 65536;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 19);
      if (sel < 2) cruise = $urandom_range(0, 60) * 65536 + $urandom_range(0, 65535);
      if (sel < 13) t = cruise + $signed($urandom_range(0, 131072)) - 65536;
      else if (sel < 15) t = -$signed($urandom_range(1, 32'h7FFF_FFFF));
      else if (sel < 17) t = $urandom_range(0, 32'h7FFF_FFFF);
      else t = $urandom;
      target_q.push_back(t);
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    period_m = longint'(RST_SAMPLE_PERIOD);
    kp_m     = longint'(RST_INJECT_KP);
    ki_m     = longint'(RST_INJECT_KI);
    bkp_m    = longint'(RST_BRAKE_KP);
    vmax_m   = longint'(RST_VELOCITY_MAX);
    mass_m   = longint'(RST_VEHICLE_MASS);
    wpk_m    = longint'(RST_PEAK_SPEED);
    ratios_m = RST_GEAR_RATIOS;
    speed_m  = 0;
    integ_m  = 0;
    lerr_m   = 0;
    gear_m   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero error, field extremes, negative target, drive then brake
    target_q.push_back(32'sd0);
    target_q.push_back(32'sh7FFF_FFFF);
    target_q.push_back(32'sh8000_0000);
    target_q.push_back(-32'sd1);
    target_q.push_back(32'sd1);
    for (int k = 0; k < 8; k++) target_q.push_back(32'sd1310720);
    target_q.push_back(32'sh4000_0000);
    target_q.push_back(32'sd655360);
    for (int k = 0; k < 4; k++) target_q.push_back(32'sd0);
    target_q.push_back(32'sh7FFF_FFFF);
    target_q.push_back(32'sh0000_FFFF);
    target_q.push_back(-32'sd655360);
    wait_idle();

    // reset settings, long receiver hold-off
    stall_mode = 1;
    queue_random(300);
    repeat (20) @(posedge clk);
    hold_req = 1'b1;
    wait_idle();

    // fast step, large gains, lightest car
    load_settings(64'd65536, 64'd16777216, 64'd16777216, 64'd16777216,
                  64'd65536, 64'd65536, 64'd65536, {$urandom, $urandom});
    stall_mode = 2;
    queue_random(300);
    wait_idle();

    // slowest step, zero gains, everything at maximum
    load_settings(64'd1, 64'd0, 64'd0, 64'd0, 64'd2147483647, 64'd2147483647,
                  64'd2147483647, 64'hFFFF_FFFF_FFFF_FFFF);
    stall_mode = 0;
    queue_random(250);
    wait_idle();

    // divisors written as zero, gears all zero
    load_settings(64'd6554, 64'd131072, 64'd6554, 64'd65536, 64'd0, 64'd0, 64'd0, 64'd0);
    stall_mode = 3;
    queue_random(200);
    wait_idle();

    // random words with bits above each register width
    load_settings({$urandom, $urandom} | 64'd1, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
    stall_mode = 1;
    queue_random(250);
    wait_idle();

    // realistic car: ratios 3.0 2.0 1.4 1.0, one second step
    load_settings(64'd65536, 64'd32768, 64'd3277, 64'd16384, 64'd2621440,
                  64'd65536000, 64'd13107200, 64'h0100_0166_0200_0300);
    stall_mode = 2;
    queue_random(700);
    wait_idle();

    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
